// ===== sv/wph_pkg.sv =====
package wph_pkg;

  localparam int unsigned CfgIdxWidth = 3;

  typedef enum logic [CfgIdxWidth-1:0] {
    REG_LEFT   = 3'd0,
    REG_BOTTOM = 3'd1,
    REG_RIGHT  = 3'd2,
    REG_TOP    = 3'd3,
    REG_CX     = 3'd4,
    REG_CY     = 3'd5
  } reg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EDGE,
    ST_DIV,
    ST_CLOSE,
    ST_OUT
  } state_e;

  // test codes for one edge, in issue order
  typedef enum logic [2:0] {
    T_LEFT   = 3'd0,
    T_RIGHT  = 3'd1,
    T_BOTTOM = 3'd2,
    T_TOP    = 3'd3,
    T_ABOVE  = 3'd4
  } test_e;

endpackage

// ===== sv/wph_if.sv =====
interface wph_if #(
  parameter int unsigned W = 16
);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== sv/wph_div.sv =====
// Restoring signed divider, one quotient bit a cycle, truncating toward zero.
module wph_div #(
  parameter int unsigned NW = 34,
  parameter int unsigned DW = 17
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic signed [NW-1:0] num_i,
  input  logic signed [DW-1:0] den_i,
  output logic                 done_o,
  output logic signed [NW-1:0] quo_o
);
  localparam int unsigned CW = $clog2(NW + 1);

  logic [NW-1:0] q_q, q_d;
  logic [DW:0]   r_q, r_d;
  logic [DW-1:0] dm_q, dm_d;
  logic          neg_q, neg_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          busy_q, busy_d;
  logic          done_q;
  logic [DW:0]   trial;
  logic [DW:0]   shifted;

  always_comb begin
    q_d = q_q; r_d = r_q; dm_d = dm_q; neg_d = neg_q;
    cnt_d = cnt_q; busy_d = busy_q;
    shifted = '0; trial = '0;
    if (start_i) begin
      q_d    = num_i[NW-1] ? NW'(-num_i) : num_i;
      dm_d   = den_i[DW-1] ? DW'(-den_i) : den_i;
      neg_d  = num_i[NW-1] ^ den_i[DW-1];
      r_d    = '0;
      cnt_d  = CW'(NW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      shifted = {r_q[DW-1:0], q_q[NW-1]};
      trial   = shifted - {1'b0, dm_q};
      if (!trial[DW]) begin
        r_d = trial;
        q_d = {q_q[NW-2:0], 1'b1};
      end else begin
        r_d = shifted;
        q_d = {q_q[NW-2:0], 1'b0};
      end
      cnt_d = cnt_q - CW'(1);
      if (cnt_q == CW'(1)) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
      // flag the cycle in which the last quotient bit has landed in q_q
      done_q <= busy_q && (cnt_q == CW'(1));
    end
  end

  always_ff @(posedge clk_i) begin
    q_q   <= q_d;
    r_q   <= r_d;
    dm_q  <= dm_d;
    neg_q <= neg_d;
  end

  assign done_o = done_q;
  assign quo_o  = neg_q ? -$signed(q_q) : $signed(q_q);
endmodule

// ===== sv/window_polygon_hit_test.sv =====
// Channel | Dir | Payload                              | Accepted when
// cfg     | in  | index[2:0], data[COORD_WIDTH-1:0]    | cfg_valid_i & cfg_ready_o
// vertex  | in  | vertex_x, vertex_y, last_vertex      | in.valid & in.ready
// result  | out | hit                                  | out.valid & out.ready
//
// Each edge runs five tests (four window sides, then the centre test) through
// one shared multiplier and one shared bit-serial divider. A test goes through
// the multiplier and divider only when the edge crosses its line; otherwise it
// is skipped. The marked vertex runs its closing edge too before its result.
// Reset is asynchronous and clears control, configuration and polygon state.
// The result waits in its register; no new vertex is taken until it leaves.
module window_polygon_hit_test #(
  parameter int unsigned COORD_WIDTH = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [wph_pkg::CfgIdxWidth-1:0]      cfg_index_i,
  input  logic [COORD_WIDTH-1:0]               cfg_data_i,
  wph_if.sink                                  in_if,
  wph_if.source                                out_if
);
  import wph_pkg::*;

  localparam int unsigned W  = COORD_WIDTH;
  localparam int unsigned DW = W + 1;
  localparam int unsigned NW = 2 * W + 2;

  logic signed [W-1:0] left_q, bottom_q, right_q, top_q, cx_q, cy_q;
  logic signed [W-1:0] fx_q, fy_q, px_q, py_q, vx_q, vy_q;
  logic                last_q, have_prev_q, hit_seen_q, parity_q, hit_q;
  state_e              state_q, state_d;
  test_e               test_q, test_d;

  // edge endpoints for the edge under test
  logic signed [W-1:0] ax, ay, bx, by;
  logic                closing_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q <= '0; bottom_q <= '0; right_q <= '0; top_q <= '0;
      cx_q <= '0; cy_q <= '0;
    end else if (cfg_valid_i) begin
      case (reg_idx_e'(cfg_index_i))
        REG_LEFT:   left_q   <= cfg_data_i;
        REG_BOTTOM: bottom_q <= cfg_data_i;
        REG_RIGHT:  right_q  <= cfg_data_i;
        REG_TOP:    top_q    <= cfg_data_i;
        REG_CX:     cx_q     <= cfg_data_i;
        REG_CY:     cy_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign ax = closing_q ? vx_q : px_q;
  assign ay = closing_q ? vy_q : py_q;
  assign bx = closing_q ? fx_q : vx_q;
  assign by = closing_q ? fy_q : vy_q;

  // per-test operand selection: base + dir*(s - a)/(d) with crossing check
  logic signed [DW-1:0] dx, dy;
  logic signed [DW-1:0] mul_a, mul_b, den, sdist, base;
  logic signed [W-1:0]  lo, hi;
  logic                 applies;
  logic                 is_above;

  assign dx = DW'(bx) - DW'(ax);
  assign dy = DW'(by) - DW'(ay);

  always_comb begin
    mul_a = dy; sdist = '0; den = dx; base = DW'(ay);
    lo = bottom_q; hi = top_q; applies = 1'b0; is_above = 1'b0;
    case (test_q)
      T_LEFT: begin
        applies = (ax < left_q) != (bx < left_q);
        sdist = DW'(left_q) - DW'(ax);
      end
      T_RIGHT: begin
        applies = (ax < right_q) != (bx < right_q);
        sdist = DW'(right_q) - DW'(ax);
      end
      T_BOTTOM: begin
        applies = (ay < bottom_q) != (by < bottom_q);
        mul_a = dx; den = dy; base = DW'(ax); lo = left_q; hi = right_q;
        sdist = DW'(bottom_q) - DW'(ay);
      end
      T_TOP: begin
        applies = (ay < top_q) != (by < top_q);
        mul_a = dx; den = dy; base = DW'(ax); lo = left_q; hi = right_q;
        sdist = DW'(top_q) - DW'(ay);
      end
      T_ABOVE: begin
        is_above = 1'b1;
        if (bx > ax) begin
          applies = (cx_q <= bx) && (cx_q >= ax);
          sdist = DW'(cx_q) - DW'(ax);
        end else if (bx < ax) begin
          applies = (cx_q <= ax) && (cx_q >= bx);
          sdist = DW'(ax) - DW'(cx_q);
          den = -dx;
        end
      end
      default: ;
    endcase
    mul_b = sdist;
  end

  // shared multiplier, registered before the divider
  logic signed [NW-1:0] prod_q;
  logic signed [DW-1:0] den_q, base_q;
  logic signed [W-1:0]  lo_q, hi_q;
  logic                 div_start, div_done;
  logic signed [NW-1:0] quo;

  always_ff @(posedge clk_i) begin
    if (state_q == ST_EDGE && applies) begin
      prod_q <= NW'(mul_a * mul_b);
      den_q  <= den;
      base_q <= base;
      lo_q   <= lo;
      hi_q   <= hi;
    end
  end

  logic div_go_q;
  wph_div #(.NW(NW), .DW(DW)) u_div (
    .clk_i, .rst_ni,
    .start_i(div_start), .num_i(prod_q), .den_i(den_q),
    .done_o(div_done), .quo_o(quo)
  );
  assign div_start = div_go_q;

  logic signed [NW:0] tval;
  assign tval = (NW+1)'(base_q) + (NW+1)'(quo);

  logic cross_ok, above_ok;
  assign cross_ok = (tval >= (NW+1)'(lo_q)) && (tval <= (NW+1)'(hi_q));
  assign above_ok = tval >= (NW+1)'(cy_q);

  logic in_win;
  assign in_win = ($signed(in_if.data[W-1:0]) >= left_q) &&
                  ($signed(in_if.data[W-1:0]) <= right_q) &&
                  ($signed(in_if.data[2*W-1:W]) >= bottom_q) &&
                  ($signed(in_if.data[2*W-1:W]) <= top_q);

  logic accept;
  assign accept = in_if.valid && in_if.ready;
  assign in_if.ready = (state_q == ST_IDLE);

  always_comb begin
    state_d = state_q;
    test_d  = test_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          test_d = T_LEFT;
          if (have_prev_q) state_d = ST_EDGE;
          else state_d = ST_CLOSE;
        end
      end
      ST_EDGE: begin
        if (applies) state_d = ST_DIV;
        else if (test_q == T_ABOVE) state_d = ST_CLOSE;
        else test_d = test_e'(test_q + 3'd1);
      end
      ST_DIV: begin
        if (div_done) begin
          if (test_q == T_ABOVE) state_d = ST_CLOSE;
          else begin
            test_d = test_e'(test_q + 3'd1);
            state_d = ST_EDGE;
          end
        end
      end
      ST_CLOSE: begin
        test_d = T_LEFT;
        if (last_q && !closing_q && have_prev_q) state_d = ST_EDGE;
        else if (last_q) state_d = ST_OUT;
        else state_d = ST_IDLE;
      end
      ST_OUT: if (out_if.ready) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE; test_q <= T_LEFT; closing_q <= 1'b0;
      have_prev_q <= 1'b0; hit_seen_q <= 1'b0; parity_q <= 1'b0;
      div_go_q <= 1'b0; last_q <= 1'b0; hit_q <= 1'b0;
      fx_q <= '0; fy_q <= '0; px_q <= '0; py_q <= '0; vx_q <= '0; vy_q <= '0;
    end else begin
      state_q  <= state_d;
      test_q   <= test_d;
      div_go_q <= (state_q == ST_EDGE) && applies;
      case (state_q)
        ST_IDLE: if (accept) begin
          vx_q <= in_if.data[W-1:0];
          vy_q <= in_if.data[2*W-1:W];
          last_q <= in_if.data[2*W];
          closing_q <= 1'b0;
          if (in_win) hit_seen_q <= 1'b1;
          if (!have_prev_q) begin
            fx_q <= in_if.data[W-1:0];
            fy_q <= in_if.data[2*W-1:W];
          end
        end
        ST_DIV: if (div_done) begin
          if (is_above) begin
            if (above_ok) parity_q <= ~parity_q;
          end else if (cross_ok) hit_seen_q <= 1'b1;
        end
        ST_CLOSE: begin
          // single-vertex closing edge is degenerate; skip it
          if (last_q && !closing_q) closing_q <= 1'b1;
          if (!closing_q) begin
            px_q <= vx_q; py_q <= vy_q; have_prev_q <= 1'b1;
          end
          if (last_q && closing_q) hit_q <= hit_seen_q || parity_q;
          if (!have_prev_q && last_q) hit_q <= hit_seen_q;
          if (last_q && (closing_q || !have_prev_q)) begin
            closing_q <= 1'b0;
            have_prev_q <= 1'b0; hit_seen_q <= 1'b0; parity_q <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  assign out_if.valid   = (state_q == ST_OUT);
  assign out_if.data[0] = hit_q;

  a_busy_not_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> !in_if.ready) else $error("ready while busy");
  a_div_from_edge: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_go_q |-> $past(state_q) == ST_EDGE) else $error("divider start stray");
  a_out_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_if.valid && !out_if.ready) |=> out_if.valid && $stable(hit_q))
    else $error("result dropped");
endmodule

// ===== tb/window_polygon_hit_test_tb.sv =====
module window_polygon_hit_test_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import wph_pkg::*;

  localparam int unsigned CW = 16;
  localparam int PolysPerPhase = 32;

  typedef logic signed [CW-1:0] coord_t;

  // One row of the directed table. Where ref_valid is set, the hit is fixed by
  // hand; otherwise the polygon predictor supplies it.
  typedef struct {
    coord_t x;
    coord_t y;
    bit     last;
    bit     ref_valid;
    bit     ref_hit;
  } vertex_row_t;

  logic       clk;
  logic       rst_n;
  logic       cfg_valid;
  logic       cfg_ready;
  reg_idx_e   cfg_index;
  coord_t     cfg_data;

  wph_if #(.W(2*CW+1)) vtx_if ();
  wph_if #(.W(1))      hit_if ();

  window_polygon_hit_test #(
    .COORD_WIDTH(CW)
  ) i_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data),
    .in_if      (vtx_if),
    .out_if     (hit_if)
  );

  // Window and centre as the predictor sees them
  longint win_left, win_bottom, win_right, win_top, ctr_x, ctr_y;
  // Polygon walk state of the predictor
  longint poly_first_x, poly_first_y, poly_prev_x, poly_prev_y;
  bit     poly_open, poly_touched, poly_above_odd;

  bit     hit_queue[$];
  int     error_count;
  int     long_hold;   // one-off receiver hold-off, in cycles
  bit     no_idle;     // stretch with both sides at full rate

  vertex_row_t dir_rows[15];

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Edge against the vertical line x = sx, hit if the crossing lies in the y span
  function automatic bit crosses_vert(longint ax, longint ay, longint bx, longint by,
                                      longint sx);
    longint t;
    if ((ax < sx) == (bx < sx)) return 1'b0;
    t = ay + (by - ay) * (sx - ax) / (bx - ax);
    return (t >= win_bottom) && (t <= win_top);
  endfunction

  // Edge against the horizontal line y = sy, hit if the crossing lies in the x span
  function automatic bit crosses_horiz(longint ax, longint ay, longint bx, longint by,
                                       longint sy);
    longint t;
    if ((ay < sy) == (by < sy)) return 1'b0;
    t = ax + (bx - ax) * (sy - ay) / (by - ay);
    return (t >= win_left) && (t <= win_right);
  endfunction

  function automatic void walk_edge(longint ax, longint ay, longint bx, longint by);
    bit above;
    above = 1'b0;
    if (crosses_vert(ax, ay, bx, by, win_left) || crosses_vert(ax, ay, bx, by, win_right) ||
        crosses_horiz(ax, ay, bx, by, win_bottom) || crosses_horiz(ax, ay, bx, by, win_top))
      poly_touched = 1'b1;
    // vertical edges never count as above the centre
    if (bx > ax) begin
      if (ctr_x <= bx && ctr_x >= ax)
        above = ctr_y <= ay + (by - ay) * (ctr_x - ax) / (bx - ax);
    end else if (bx < ax) begin
      if (ctr_x <= ax && ctr_x >= bx)
        above = ctr_y <= ay + (by - ay) * (ax - ctr_x) / (ax - bx);
    end
    if (above) poly_above_odd = !poly_above_odd;
  endfunction

  // Advance the polygon walk by one vertex; returns 1 when a hit result is due
  function automatic bit walk_vertex(coord_t vx_c, coord_t vy_c, bit last, output bit hit);
    longint vx, vy;
    vx = vx_c;
    vy = vy_c;
    hit = 1'b0;
    if (vx >= win_left && vx <= win_right && vy >= win_bottom && vy <= win_top)
      poly_touched = 1'b1;
    if (poly_open) begin
      walk_edge(poly_prev_x, poly_prev_y, vx, vy);
    end else begin
      poly_first_x = vx;
      poly_first_y = vy;
    end
    poly_prev_x = vx;
    poly_prev_y = vy;
    poly_open   = 1'b1;
    if (!last) return 1'b0;
    walk_edge(vx, vy, poly_first_x, poly_first_y);
    hit = poly_touched || poly_above_odd;
    poly_open      = 1'b0;
    poly_touched   = 1'b0;
    poly_above_odd = 1'b0;
    return 1'b1;
  endfunction

  task automatic write_reg(reg_idx_e idx, coord_t val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_LEFT:   win_left   = val;
      REG_BOTTOM: win_bottom = val;
      REG_RIGHT:  win_right  = val;
      REG_TOP:    win_top    = val;
      REG_CX:     ctr_x      = val;
      REG_CY:     ctr_y      = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic write_window(coord_t l, coord_t b, coord_t r, coord_t t, coord_t cx,
                              coord_t cy);
    write_reg(REG_LEFT, l);
    write_reg(REG_BOTTOM, b);
    write_reg(REG_RIGHT, r);
    write_reg(REG_TOP, t);
    write_reg(REG_CX, cx);
    write_reg(REG_CY, cy);
  endtask

  // Called at a falling edge; returns at the falling edge after the transaction.
  // valid is only lowered when a gap is drawn, so back-to-back items keep it high.
  task automatic send_vertex(coord_t x, coord_t y, bit last, bit ref_valid, bit ref_hit);
    int gap;
    bit due, hit;
    gap = no_idle ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      vtx_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    vtx_if.valid <= 1'b1;
    vtx_if.data  <= {last, y, x};
    do @(posedge clk); while (!vtx_if.ready);
    due = walk_vertex(x, y, last, hit);
    if (due) hit_queue.push_back(ref_valid ? ref_hit : hit);
    @(negedge clk);
  endtask

  // Drop valid and hold until the block has settled after its last result
  task automatic drain_block();
    vtx_if.valid <= 1'b0;
    while (hit_queue.size() != 0) @(negedge clk);
    repeat (400) @(negedge clk);
  endtask

  // Half the draws span the whole field, the rest land near the window
  function automatic coord_t pick_coord(longint lo, longint hi);
    longint c;
    if ($urandom_range(0, 1) == 0) return coord_t'($urandom);
    c = (lo + hi) / 2 + $signed($urandom_range(0, 400)) - 200;
    if ($urandom_range(0, 3) == 0) c = ($urandom_range(0, 1) ? lo : hi);
    if (c > 32767) c = 32767;
    if (c < -32768) c = -32768;
    return coord_t'(c);
  endfunction

  task automatic send_polygon();
    int n;
    coord_t x, y;
    n = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(2, 8);
    for (int k = 0; k < n; k++) begin
      x = pick_coord(win_left, win_right);
      y = pick_coord(win_bottom, win_top);
      send_vertex(x, y, k == n - 1, 1'b0, 1'b0);
    end
  endtask

  // Result side: random hold-off per transaction, compare against the oldest prediction
  initial begin
    int gap;
    hit_if.ready <= 1'b0;
    @(negedge clk);
    forever begin
      if (long_hold > 0) begin
        gap = long_hold;
        long_hold = 0;
      end else begin
        gap = no_idle ? 0 : $urandom_range(0, 5);
      end
      if (gap > 0) begin
        hit_if.ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      hit_if.ready <= 1'b1;
      do @(posedge clk); while (!hit_if.valid);
      if (hit_queue.size() == 0) begin
        $display("%0t: hit result %0d with nothing expected", $time, hit_if.data[0]);
        error_count++;
      end else if (hit_queue[0] !== hit_if.data[0]) begin
        $display("%0t: hit mismatch, expected %0d actual %0d", $time, hit_queue[0],
                 hit_if.data[0]);
        error_count++;
        void'(hit_queue.pop_front());
      end else begin
        void'(hit_queue.pop_front());
      end
      @(negedge clk);
    end
  end

  initial begin
    #50ms;
    $display("window_polygon_hit_test regression: fail");
    $finish;
  end

  initial begin
    int sent;
    rst_n        <= 1'b0;
    cfg_valid    <= 1'b0;
    cfg_index    <= REG_LEFT;
    cfg_data     <= '0;
    vtx_if.valid <= 1'b0;
    vtx_if.data  <= '0;
    error_count  = 0;
    long_hold    = 0;
    no_idle      = 1'b0;
    win_left = 0; win_bottom = 0; win_right = 0; win_top = 0; ctr_x = 0; ctr_y = 0;
    poly_first_x = 0; poly_first_y = 0; poly_prev_x = 0; poly_prev_y = 0;
    poly_open = 1'b0; poly_touched = 1'b0; poly_above_odd = 1'b0;

    // After reset the window is the single point at the origin, centre there too
    dir_rows[0]  = '{16'sd0, 16'sd0, 1'b1, 1'b1, 1'b1};
    dir_rows[1]  = '{16'sd1, 16'sd1, 1'b1, 1'b1, 1'b0};
    dir_rows[2]  = '{16'sd32767, 16'sd32767, 1'b1, 1'b1, 1'b0};
    dir_rows[3]  = '{-16'sd32768, -16'sd32768, 1'b1, 1'b1, 1'b0};
    // full-range diagonal and back
    dir_rows[4]  = '{-16'sd32768, 16'sd32767, 1'b0, 1'b0, 1'b0};
    dir_rows[5]  = '{16'sd32767, -16'sd32768, 1'b1, 1'b0, 1'b0};
    // triangle around the centre
    dir_rows[6]  = '{-16'sd100, -16'sd100, 1'b0, 1'b0, 1'b0};
    dir_rows[7]  = '{16'sd100, -16'sd100, 1'b0, 1'b0, 1'b0};
    dir_rows[8]  = '{16'sd0, 16'sd100, 1'b1, 1'b0, 1'b0};
    // vertical and horizontal edges
    dir_rows[9]  = '{16'sd5, -16'sd10, 1'b0, 1'b0, 1'b0};
    dir_rows[10] = '{16'sd5, 16'sd10, 1'b1, 1'b0, 1'b0};
    dir_rows[11] = '{-16'sd10, 16'sd5, 1'b0, 1'b0, 1'b0};
    dir_rows[12] = '{16'sd10, 16'sd5, 1'b1, 1'b0, 1'b0};
    // vertex on the window makes a hit whatever follows
    dir_rows[13] = '{16'sd0, 16'sd0, 1'b0, 1'b0, 1'b0};
    dir_rows[14] = '{16'sd500, 16'sd500, 1'b1, 1'b1, 1'b1};

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (dir_rows[i])
      send_vertex(dir_rows[i].x, dir_rows[i].y, dir_rows[i].last, dir_rows[i].ref_valid,
                  dir_rows[i].ref_hit);
    drain_block();

    sent = 0;
    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0: write_window(-16'sd32768, -16'sd32768, 16'sd32767, 16'sd32767, 16'sd0, 16'sd0);
        1: write_window(16'sd100, 16'sd100, -16'sd100, -16'sd100, 16'sd0, 16'sd0);
        2: write_window(16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767,
                        -16'sd32768, -16'sd32768);
        3: write_window(-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768,
                        16'sd32767, 16'sd32767);
        default: begin
          coord_t l, b;
          l = coord_t'($urandom);
          b = coord_t'($urandom);
          write_window(l, b,
                       coord_t'((longint'(l) + longint'($urandom_range(0, 2000)) > 32767) ?
                                 32767 : longint'(l) + longint'($urandom_range(0, 2000))),
                       coord_t'((longint'(b) + longint'($urandom_range(0, 2000)) > 32767) ?
                                 32767 : longint'(b) + longint'($urandom_range(0, 2000))),
                       coord_t'($urandom), coord_t'($urandom));
        end
      endcase
      while (sent < (phase + 1) * PolysPerPhase) begin
        no_idle = ($urandom_range(0, 3) == 0);
        if (phase == 4 && sent == phase * PolysPerPhase) begin
          // stall the result side long enough for the block to back up
          no_idle   = 1'b1;
          long_hold = 600;
        end
        if (phase == 6 && sent == phase * PolysPerPhase) begin
          // pause the vertex side until every result is in
          vtx_if.valid <= 1'b0;
          while (hit_queue.size() != 0) @(negedge clk);
          @(negedge clk);
        end
        send_polygon();
        sent = sent + 1;
      end
      drain_block();
    end

    repeat (400) @(posedge clk);
    if (error_count == 0 && hit_queue.size() == 0) begin
      $display("window_polygon_hit_test regression: pass");
    end else begin
      $display("window_polygon_hit_test regression: fail");
    end
    $finish;
  end

endmodule
